/* rtl/hfe_pkg.sv */
// ----------------------------------------------------------------------------
// hfe_pkg
// Shared types and constants of the static Huffman escape encoder: command
// codes, status codes, register indexes and the codebook entry layout.
// ----------------------------------------------------------------------------
package hfe_pkg;

    localparam int BOOK_ENTRIES_DEF = 64;
    localparam int MAX_CODE_LEN_DEF = 16;
    localparam int RAW_BITS_DEF     = 16;

    localparam int CODE_W      = 16;
    localparam int SYM_W       = 16;
    localparam int LEN_W       = 5;
    localparam int TOTAL_W     = 24;
    localparam int MAX_BYTES   = 4;
    localparam int QUEUE_DEPTH = 2;

    // func field of an input word
    localparam logic [1:0] FUNC_LOAD   = 2'd0;
    localparam logic [1:0] FUNC_ENCODE = 2'd1;
    localparam logic [1:0] FUNC_FLUSH  = 2'd2;

    // operation handed from front to back
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_ENCODE = 2'd1;
    localparam logic [1:0] OP_FLUSH  = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
    localparam logic [1:0] STATUS_NO_ESCAPE = 2'd2;

    localparam logic [1:0] CFG_CHECK_ONLY     = 2'd0;
    localparam logic [1:0] CFG_BUFFER_BYTES   = 2'd1;
    localparam logic [1:0] CFG_ESCAPE_SYM     = 2'd2;
    localparam logic [1:0] CFG_ENTRIES_IN_USE = 2'd3;

    typedef struct packed {
        logic [1:0]        op;
        logic [5:0]        idx;
        logic [SYM_W-1:0]  sym;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } cmd_t;

    typedef struct packed {
        logic [SYM_W-1:0]  sym;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } book_entry_t;

    typedef struct packed {
        logic              check_only;
        logic [15:0]       buffer_bytes;
        logic [SYM_W-1:0]  escape_sym;
    } cfg_t;

    typedef struct packed {
        logic [7:0]         out_byte;
        logic               byte_valid;
        logic               last;
        logic [TOTAL_W-1:0] total_bits;
        logic [1:0]         status;
        logic               used_escape;
    } res_t;

endpackage

/* rtl/hfe_ram.sv */
// ----------------------------------------------------------------------------
// hfe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/hfe_front.sv */
// ----------------------------------------------------------------------------
// hfe_front
// Input side: takes words, decodes func into an operation, merges the
// symbol fields, saturates the code length and queues the command.
// ----------------------------------------------------------------------------
module hfe_front #(
    parameter int BOOK_ENTRIES = hfe_pkg::BOOK_ENTRIES_DEF,
    parameter int MAX_CODE_LEN = hfe_pkg::MAX_CODE_LEN_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_func,
    input  logic [5:0]         s_entry_index,
    input  logic signed [15:0] s_entry_symbol,
    input  logic [15:0]        s_entry_code,
    input  logic [4:0]         s_entry_len,
    input  logic signed [15:0] s_symbol,
    output logic               cmd_valid,
    input  logic               cmd_ready,
    output hfe_pkg::cmd_t      cmd
);

    localparam int PTR_W = $clog2(hfe_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(hfe_pkg::QUEUE_DEPTH + 1);

    hfe_pkg::cmd_t    q_reg [hfe_pkg::QUEUE_DEPTH];
    hfe_pkg::cmd_t    cls;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    // classify
    always_comb begin
        cls.idx  = s_entry_index;
        cls.code = s_entry_code;
        cls.sym  = (s_func == hfe_pkg::FUNC_LOAD) ? unsigned'(s_entry_symbol)
                                                  : unsigned'(s_symbol);
        cls.len  = (32'(s_entry_len) > MAX_CODE_LEN) ? hfe_pkg::LEN_W'(MAX_CODE_LEN)
                                                     : s_entry_len;
        case (s_func)
            hfe_pkg::FUNC_LOAD: begin
                cls.op = (32'(s_entry_index) < BOOK_ENTRIES) ? hfe_pkg::OP_LOAD
                                                             : hfe_pkg::OP_NOP;
            end
            hfe_pkg::FUNC_ENCODE: cls.op = hfe_pkg::OP_ENCODE;
            hfe_pkg::FUNC_FLUSH:  cls.op = hfe_pkg::OP_FLUSH;
            default:              cls.op = hfe_pkg::OP_NOP;
        endcase
    end

    assign s_ready   = (count_reg != CNT_W'(hfe_pkg::QUEUE_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push      = s_valid && s_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(hfe_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(hfe_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

/* rtl/hfe_engine.sv */
// ----------------------------------------------------------------------------
// hfe_engine
// Back side: writes the codebook RAM, searches it one slot a cycle, packs
// code and raw bits into bytes, keeps the bit counters and sends results.
// ----------------------------------------------------------------------------
module hfe_engine #(
    parameter int BOOK_ENTRIES = hfe_pkg::BOOK_ENTRIES_DEF,
    parameter int RAW_BITS     = hfe_pkg::RAW_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cmd_valid,
    output logic                              cmd_ready,
    input  hfe_pkg::cmd_t                     cmd,
    input  hfe_pkg::cfg_t                     cfg,
    input  logic [$clog2(BOOK_ENTRIES+1)-1:0] entries,
    output logic                              m_valid,
    input  logic                              m_ready,
    output hfe_pkg::res_t                     res
);

    localparam int AW     = $clog2(BOOK_ENTRIES);
    localparam int CNT_W  = $clog2(BOOK_ENTRIES + 1);
    localparam int BW     = $clog2(hfe_pkg::MAX_BYTES);
    localparam int NB_W   = $clog2(hfe_pkg::MAX_BYTES + 1);
    localparam int ENT_W  = $bits(hfe_pkg::book_entry_t);
    localparam int RAW_SH = hfe_pkg::CODE_W - RAW_BITS;
    localparam logic [hfe_pkg::LEN_W-1:0] RAW_LEN = hfe_pkg::LEN_W'(RAW_BITS);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_PUT    = 3'd2;
    localparam logic [2:0] S_COUNT  = 3'd3;
    localparam logic [2:0] S_REPORT = 3'd4;

    function automatic logic [hfe_pkg::TOTAL_W-1:0] sat_add(
        input logic [hfe_pkg::TOTAL_W-1:0] t,
        input logic [5:0]                  n
    );
        logic [hfe_pkg::TOTAL_W:0] s;
        s = {1'b0, t} + (hfe_pkg::TOTAL_W+1)'(n);
        return s[hfe_pkg::TOTAL_W] ? '1 : s[hfe_pkg::TOTAL_W-1:0];
    endfunction

    function automatic logic [hfe_pkg::CODE_W-1:0] align_code(
        input logic [hfe_pkg::CODE_W-1:0] code,
        input logic [hfe_pkg::LEN_W-1:0]  len
    );
        return hfe_pkg::CODE_W'(code << (hfe_pkg::LEN_W'(hfe_pkg::CODE_W) - len));
    endfunction

    logic [2:0]                  state_reg, state_next;
    logic [hfe_pkg::SYM_W-1:0]   cur_sym_reg, cur_sym_next;
    logic [AW-1:0]               chk_idx_reg, chk_idx_next;
    logic                        esc_found_reg, esc_found_next;
    logic [hfe_pkg::CODE_W-1:0]  esc_code_reg, esc_code_next;
    logic [hfe_pkg::LEN_W-1:0]   esc_len_reg, esc_len_next;
    logic [hfe_pkg::CODE_W-1:0]  seg_aligned_reg, seg_aligned_next;
    logic [hfe_pkg::LEN_W-1:0]   seg_rem_reg, seg_rem_next;
    logic [hfe_pkg::LEN_W-1:0]   seg_len_reg, seg_len_next;
    logic                        raw_pending_reg, raw_pending_next;
    logic [5:0]                  count_len_reg, count_len_next;
    logic                        escaped_reg, escaped_next;
    logic                        noesc_reg, noesc_next;
    logic                        flush_reg, flush_next;
    logic [7:0]                  partial_reg, partial_next;
    logic [2:0]                  bitpos_reg, bitpos_next;
    logic [15:0]                 byte_count_reg, byte_count_next;
    logic [hfe_pkg::TOTAL_W-1:0] bit_total_reg, bit_total_next;
    logic                        ovf_reg, ovf_next;
    logic [7:0]                  byte_buf_reg [hfe_pkg::MAX_BYTES];
    logic [7:0]                  byte_buf_next [hfe_pkg::MAX_BYTES];
    logic [NB_W-1:0]             nbytes_reg, nbytes_next;
    logic [BW-1:0]               out_idx_reg, out_idx_next;

    logic                        ram_we;
    logic [AW-1:0]               ram_raddr;
    logic [ENT_W-1:0]            ram_rdata;
    hfe_pkg::book_entry_t        rd_entry;
    hfe_pkg::book_entry_t        wr_entry;

    logic [3:0]                  room, take, pos_sum;
    logic [7:0]                  mask, merged;
    logic                        match_hit, match_esc, last_chk, esc_now;
    logic [hfe_pkg::CODE_W-1:0]  esc_code_sel;
    logic [hfe_pkg::LEN_W-1:0]   esc_len_sel;
    logic [hfe_pkg::TOTAL_W-1:0] check_total, limit_bits;
    logic                        res_last;

    assign wr_entry.sym  = cmd.sym;
    assign wr_entry.code = cmd.code;
    assign wr_entry.len  = cmd.len;
    assign ram_we    = (state_reg == S_IDLE) && cmd_valid && (cmd.op == hfe_pkg::OP_LOAD);
    assign ram_raddr = (state_reg == S_SEARCH) ? chk_idx_reg + 1'b1 : '0;
    assign rd_entry  = hfe_pkg::book_entry_t'(ram_rdata);

    hfe_ram #(
        .WIDTH (ENT_W),
        .DEPTH (BOOK_ENTRIES)
    ) u_book (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (AW'(cmd.idx)),
        .wdata (wr_entry),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // codebook search
    assign match_hit    = (rd_entry.sym == cur_sym_reg);
    assign match_esc    = (rd_entry.sym == cfg.escape_sym);
    assign last_chk     = ((CNT_W'(chk_idx_reg) + CNT_W'(1)) == entries);
    assign esc_now      = esc_found_reg || match_esc;
    assign esc_code_sel = esc_found_reg ? esc_code_reg : rd_entry.code;
    assign esc_len_sel  = esc_found_reg ? esc_len_reg : rd_entry.len;

    // bit packing, one chunk up to the byte boundary a cycle
    assign room    = 4'd8 - {1'b0, bitpos_reg};
    assign take    = (seg_rem_reg < hfe_pkg::LEN_W'(room)) ? seg_rem_reg[3:0] : room;
    assign mask    = 8'(8'hFF << (4'd8 - take));
    assign merged  = partial_reg | ((seg_aligned_reg[15:8] & mask) >> bitpos_reg);
    assign pos_sum = {1'b0, bitpos_reg} + take;

    assign check_total = sat_add(bit_total_reg, count_len_reg);
    assign limit_bits  = hfe_pkg::TOTAL_W'({cfg.buffer_bytes, 3'b000});

    always_comb begin
        state_next       = state_reg;
        cur_sym_next     = cur_sym_reg;
        chk_idx_next     = chk_idx_reg;
        esc_found_next   = esc_found_reg;
        esc_code_next    = esc_code_reg;
        esc_len_next     = esc_len_reg;
        seg_aligned_next = seg_aligned_reg;
        seg_rem_next     = seg_rem_reg;
        seg_len_next     = seg_len_reg;
        raw_pending_next = raw_pending_reg;
        count_len_next   = count_len_reg;
        escaped_next     = escaped_reg;
        noesc_next       = noesc_reg;
        flush_next       = flush_reg;
        partial_next     = partial_reg;
        bitpos_next      = bitpos_reg;
        byte_count_next  = byte_count_reg;
        bit_total_next   = bit_total_reg;
        ovf_next         = ovf_reg;
        byte_buf_next    = byte_buf_reg;
        nbytes_next      = nbytes_reg;
        out_idx_next     = out_idx_reg;

        case (state_reg)
            S_IDLE: begin
                if (cmd_valid) begin
                    nbytes_next    = '0;
                    out_idx_next   = '0;
                    escaped_next   = 1'b0;
                    noesc_next     = 1'b0;
                    flush_next     = 1'b0;
                    esc_found_next = 1'b0;
                    cur_sym_next   = cmd.sym;
                    chk_idx_next   = '0;
                    state_next     = S_REPORT;
                    case (cmd.op)
                        hfe_pkg::OP_ENCODE: begin
                            if (entries == '0) begin
                                noesc_next = 1'b1;
                            end else begin
                                state_next = S_SEARCH;
                            end
                        end
                        hfe_pkg::OP_FLUSH: begin
                            flush_next = 1'b1;
                            if (bitpos_reg != '0) begin
                                byte_buf_next[0] = partial_reg;
                                nbytes_next      = NB_W'(1);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                if (!esc_found_reg && match_esc) begin
                    esc_found_next = 1'b1;
                    esc_code_next  = rd_entry.code;
                    esc_len_next   = rd_entry.len;
                end
                if (match_hit) begin
                    count_len_next   = 6'(rd_entry.len);
                    seg_aligned_next = align_code(rd_entry.code, rd_entry.len);
                    seg_rem_next     = rd_entry.len;
                    seg_len_next     = rd_entry.len;
                    raw_pending_next = 1'b0;
                    state_next       = cfg.check_only ? S_COUNT : S_PUT;
                end else if (last_chk) begin
                    if (esc_now) begin
                        escaped_next     = 1'b1;
                        count_len_next   = 6'(esc_len_sel) + 6'(RAW_LEN);
                        seg_aligned_next = align_code(esc_code_sel, esc_len_sel);
                        seg_rem_next     = esc_len_sel;
                        seg_len_next     = esc_len_sel;
                        raw_pending_next = 1'b1;
                        state_next       = cfg.check_only ? S_COUNT : S_PUT;
                    end else begin
                        noesc_next = 1'b1;
                        state_next = S_REPORT;
                    end
                end else begin
                    chk_idx_next = chk_idx_reg + 1'b1;
                end
            end
            S_PUT: begin
                if (seg_rem_reg == '0) begin
                    bit_total_next = sat_add(bit_total_reg, 6'(seg_len_reg));
                    if (raw_pending_reg) begin
                        seg_aligned_next = hfe_pkg::CODE_W'(cur_sym_reg << RAW_SH);
                        seg_rem_next     = RAW_LEN;
                        seg_len_next     = RAW_LEN;
                        raw_pending_next = 1'b0;
                    end else begin
                        state_next = S_REPORT;
                    end
                end else if (ovf_reg) begin
                    state_next = S_REPORT;
                end else if (byte_count_reg >= cfg.buffer_bytes) begin
                    ovf_next   = 1'b1;
                    state_next = S_REPORT;
                end else begin
                    seg_aligned_next = hfe_pkg::CODE_W'(seg_aligned_reg << take);
                    seg_rem_next     = seg_rem_reg - hfe_pkg::LEN_W'(take);
                    if (pos_sum == 4'd8) begin
                        byte_buf_next[nbytes_reg[BW-1:0]] = merged;
                        nbytes_next     = nbytes_reg + 1'b1;
                        partial_next    = '0;
                        bitpos_next     = '0;
                        byte_count_next = byte_count_reg + 1'b1;
                    end else begin
                        partial_next = merged;
                        bitpos_next  = pos_sum[2:0];
                    end
                end
            end
            S_COUNT: begin
                bit_total_next = check_total;
                if (check_total > limit_bits) begin
                    ovf_next = 1'b1;
                end
                state_next = S_REPORT;
            end
            S_REPORT: begin
                if (m_ready) begin
                    if (res_last) begin
                        state_next = S_IDLE;
                        if (flush_reg) begin
                            partial_next    = '0;
                            bitpos_next     = '0;
                            byte_count_next = '0;
                            bit_total_next  = '0;
                            ovf_next        = 1'b0;
                        end
                    end else begin
                        out_idx_next = out_idx_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign cmd_ready = (state_reg == S_IDLE);
    assign m_valid   = (state_reg == S_REPORT);
    assign res_last  = (nbytes_reg == '0) || (NB_W'(out_idx_reg) == nbytes_reg - 1'b1);

    always_comb begin
        res.byte_valid  = (nbytes_reg != '0);
        res.out_byte    = res.byte_valid ? byte_buf_reg[out_idx_reg] : 8'd0;
        res.last        = res_last;
        res.total_bits  = bit_total_reg;
        res.used_escape = escaped_reg;
        if (noesc_reg) begin
            res.status = hfe_pkg::STATUS_NO_ESCAPE;
        end else if (ovf_reg) begin
            res.status = hfe_pkg::STATUS_OVERFLOW;
        end else begin
            res.status = hfe_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            escaped_reg     <= 1'b0;
            noesc_reg       <= 1'b0;
            flush_reg       <= 1'b0;
            esc_found_reg   <= 1'b0;
            raw_pending_reg <= 1'b0;
            partial_reg     <= '0;
            bitpos_reg      <= '0;
            byte_count_reg  <= '0;
            bit_total_reg   <= '0;
            ovf_reg         <= 1'b0;
            nbytes_reg      <= '0;
            out_idx_reg     <= '0;
        end else begin
            state_reg       <= state_next;
            escaped_reg     <= escaped_next;
            noesc_reg       <= noesc_next;
            flush_reg       <= flush_next;
            esc_found_reg   <= esc_found_next;
            raw_pending_reg <= raw_pending_next;
            partial_reg     <= partial_next;
            bitpos_reg      <= bitpos_next;
            byte_count_reg  <= byte_count_next;
            bit_total_reg   <= bit_total_next;
            ovf_reg         <= ovf_next;
            nbytes_reg      <= nbytes_next;
            out_idx_reg     <= out_idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_sym_reg     <= cur_sym_next;
        chk_idx_reg     <= chk_idx_next;
        esc_code_reg    <= esc_code_next;
        esc_len_reg     <= esc_len_next;
        seg_aligned_reg <= seg_aligned_next;
        seg_rem_reg     <= seg_rem_next;
        seg_len_reg     <= seg_len_next;
        count_len_reg   <= count_len_next;
        byte_buf_reg    <= byte_buf_next;
    end

endmodule

/* rtl/static_huffman_escape_encoder.sv */
// ----------------------------------------------------------------------------
// static_huffman_escape_encoder
// Static Huffman encoder with escape code and MSB-first byte packing.
//
//   channel   dir   handshake              word
//   s_        in    s_valid / s_ready      load entry, encode symbol or flush
//   m_        out   m_valid / m_ready      one packed byte or a status word
//   cfg_      in    cfg_wr_en              register write, no wait
//
// load, flush and unused words: the back end goes straight to the results.
// encode: codebook slots are read up to the first match (every slot in use
// when escaped), then bits are packed in chunks up to each byte boundary and
// code segment, or counted in the S_COUNT state in check mode. results then go
// out one per handshake; the codebook RAM is undefined until loaded.
// a two-word queue lets the input side take up to two words while results stall.
// ----------------------------------------------------------------------------
module static_huffman_escape_encoder #(
    parameter int BOOK_ENTRIES = hfe_pkg::BOOK_ENTRIES_DEF,
    parameter int MAX_CODE_LEN = hfe_pkg::MAX_CODE_LEN_DEF,
    parameter int RAW_BITS     = hfe_pkg::RAW_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_func,
    input  logic [5:0]         s_entry_index,
    input  logic signed [15:0] s_entry_symbol,
    input  logic [15:0]        s_entry_code,
    input  logic [4:0]         s_entry_len,
    input  logic signed [15:0] s_symbol,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_out_byte,
    output logic               m_byte_valid,
    output logic               m_last,
    output logic [23:0]        m_total_bits,
    output logic [1:0]         m_status,
    output logic               m_used_escape
);

    localparam int CNT_W = $clog2(BOOK_ENTRIES + 1);

    logic          check_only_reg;
    logic [15:0]   buffer_bytes_reg;
    logic [15:0]   escape_sym_reg;
    logic [6:0]    entries_reg;
    logic [CNT_W-1:0] entries_used;
    hfe_pkg::cfg_t cfg;
    hfe_pkg::cmd_t cmd;
    hfe_pkg::res_t res;
    logic          cmd_valid, cmd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            check_only_reg   <= 1'b0;
            buffer_bytes_reg <= 16'hFFFF;
            escape_sym_reg   <= 16'h8000;
            entries_reg      <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                hfe_pkg::CFG_CHECK_ONLY:     check_only_reg   <= cfg_wdata[0];
                hfe_pkg::CFG_BUFFER_BYTES:   buffer_bytes_reg <= cfg_wdata;
                hfe_pkg::CFG_ESCAPE_SYM:     escape_sym_reg   <= cfg_wdata;
                hfe_pkg::CFG_ENTRIES_IN_USE: entries_reg      <= cfg_wdata[6:0];
                default: begin
                end
            endcase
        end
    end

    // slots searched, clamped to the codebook depth
    assign entries_used = (32'(entries_reg) > BOOK_ENTRIES) ? CNT_W'(BOOK_ENTRIES)
                                                            : CNT_W'(entries_reg);

    assign cfg.check_only   = check_only_reg;
    assign cfg.buffer_bytes = buffer_bytes_reg;
    assign cfg.escape_sym   = escape_sym_reg;

    hfe_front #(
        .BOOK_ENTRIES (BOOK_ENTRIES),
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_entry_index  (s_entry_index),
        .s_entry_symbol (s_entry_symbol),
        .s_entry_code   (s_entry_code),
        .s_entry_len    (s_entry_len),
        .s_symbol       (s_symbol),
        .cmd_valid      (cmd_valid),
        .cmd_ready      (cmd_ready),
        .cmd            (cmd)
    );

    hfe_engine #(
        .BOOK_ENTRIES (BOOK_ENTRIES),
        .RAW_BITS     (RAW_BITS)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .cfg       (cfg),
        .entries   (entries_used),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .res       (res)
    );

    assign m_out_byte    = res.out_byte;
    assign m_byte_valid  = res.byte_valid;
    assign m_last        = res.last;
    assign m_total_bits  = res.total_bits;
    assign m_status      = res.status;
    assign m_used_escape = res.used_escape;

`ifndef NO_ASSERTIONS
    a_noesc_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == hfe_pkg::STATUS_NO_ESCAPE) |-> (!m_byte_valid && !m_used_escape))
        else $error("no-escape result carries a byte or escape flag");

    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_byte_valid) |-> m_last)
        else $error("result without a byte is not the last of its word");

    a_take_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd_valid && cmd_ready) |-> !m_valid)
        else $error("command taken while results are pending");

    a_last_ends_report: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last) |=> !m_valid)
        else $error("results continue after the last word");
`endif

endmodule

/* tb/static_huffman_escape_encoder_tb.sv */
// ----------------------------------------------------------------------------
// static_huffman_escape_encoder_tb
// Self-checking bench for the static Huffman escape encoder. A bit-exact
// software copy of the encoder tracks the codebook, the byte packer, the bit
// total and the sticky overflow, and predicts every output word. Directed
// words cover codebook corner cases, escape handling, check mode, overflow and
// flush; random traffic then runs under several register settings, with
// sender gaps, receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module static_huffman_escape_encoder_tb;

    localparam int          SLOTS          = hfe_pkg::BOOK_ENTRIES_DEF;
    localparam int          RAW_LEN        = hfe_pkg::RAW_BITS_DEF;
    localparam int unsigned TOTAL_SAT      = 32'h00FF_FFFF;
    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          HOLD_CYCLES    = 400;
    localparam logic [1:0]  FUNC_UNUSED    = 2'd3;

    logic               aclk           = 1'b0;
    logic               aresetn        = 1'b0;
    logic               cfg_wr_en      = 1'b0;
    logic [1:0]         cfg_index      = hfe_pkg::CFG_CHECK_ONLY;
    logic [15:0]        cfg_wdata      = '0;
    logic               s_valid        = 1'b0;
    logic               s_ready;
    logic [1:0]         s_func         = hfe_pkg::FUNC_LOAD;
    logic [5:0]         s_entry_index  = '0;
    logic signed [15:0] s_entry_symbol = '0;
    logic [15:0]        s_entry_code   = '0;
    logic [4:0]         s_entry_len    = '0;
    logic signed [15:0] s_symbol       = '0;
    logic               m_valid;
    logic               m_ready        = 1'b0;
    logic [7:0]         m_out_byte;
    logic               m_byte_valid;
    logic               m_last;
    logic [23:0]        m_total_bits;
    logic [1:0]         m_status;
    logic               m_used_escape;

    // encoder copy: registers
    logic        chk_mode  = 1'b0;
    logic [15:0] buf_limit = 16'hFFFF;
    logic [15:0] esc_sym   = 16'h8000;
    logic [6:0]  n_slots   = '0;

    // encoder copy: codebook and stream state
    logic [15:0] bk_sym  [SLOTS];
    logic [15:0] bk_code [SLOTS];
    logic [4:0]  bk_len  [SLOTS];
    logic [7:0]  acc_byte  = '0;
    int          acc_bits  = 0;
    logic [15:0] bytes_out = '0;
    int unsigned bits_sent = 0;
    logic        ovf       = 1'b0;
    logic [7:0]  new_bytes [$];

    hfe_pkg::res_t coded_words_q [$];
    int   errors       = 0;
    int   idle_pct     = 0;
    int   stall_pct    = 0;
    int   hold_request = 0;
    int   hold_left    = 0;
    int   quiet_cycles = 0;

    static_huffman_escape_encoder u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_entry_index  (s_entry_index),
        .s_entry_symbol (s_entry_symbol),
        .s_entry_code   (s_entry_code),
        .s_entry_len    (s_entry_len),
        .s_symbol       (s_symbol),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_byte_valid   (m_byte_valid),
        .m_last         (m_last),
        .m_total_bits   (m_total_bits),
        .m_status       (m_status),
        .m_used_escape  (m_used_escape)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic void add_bits(input int unsigned n);
        bits_sent = (bits_sent + n > TOTAL_SAT) ? TOTAL_SAT : bits_sent + n;
    endfunction

    function automatic bit emit_bits(input logic [15:0] value, input int len);
        logic cur_bit;
        for (int i = 0; i < len; i++) begin
            cur_bit = value[len - 1 - i];
            if (ovf)
                return 1'b0;
            if (bytes_out >= buf_limit) begin
                ovf = 1'b1;
                return 1'b0;
            end
            if (cur_bit)
                acc_byte[7 - acc_bits] = 1'b1;
            acc_bits++;
            if (acc_bits == 8) begin
                new_bytes.push_back(acc_byte);
                acc_byte = '0;
                acc_bits = 0;
                bytes_out++;
            end
        end
        return 1'b1;
    endfunction

    function automatic int find_slot(input logic [15:0] s);
        int n;
        n = (n_slots > SLOTS) ? SLOTS : int'(n_slots);
        for (int i = 0; i < n; i++)
            if (bk_sym[i] == s)
                return i;
        return -1;
    endfunction

    function automatic void encode_item(input logic [1:0] func, input logic [5:0] idx,
                                        input logic [15:0] esym, input logic [15:0] ecode,
                                        input logic [4:0] elen, input logic [15:0] sym);
        int            hit;
        int            esc;
        int            nres;
        logic [1:0]    st;
        logic          escaped;
        logic [23:0]   rep;
        hfe_pkg::res_t w;
        escaped = 1'b0;
        new_bytes.delete();
        case (func)
            hfe_pkg::FUNC_LOAD: begin
                bk_sym[idx]  = esym;
                bk_code[idx] = ecode;
                bk_len[idx]  = (elen > hfe_pkg::MAX_CODE_LEN_DEF) ?
                               5'(hfe_pkg::MAX_CODE_LEN_DEF) : elen;
                st  = ovf ? hfe_pkg::STATUS_OVERFLOW : hfe_pkg::STATUS_OK;
                rep = 24'(bits_sent);
            end
            hfe_pkg::FUNC_ENCODE: begin
                hit = find_slot(sym);
                esc = find_slot(esc_sym);
                if (hit < 0 && esc < 0) begin
                    st = hfe_pkg::STATUS_NO_ESCAPE;
                end else begin
                    escaped = (hit < 0);
                    if (chk_mode) begin
                        if (hit >= 0)
                            add_bits(bk_len[hit]);
                        else
                            add_bits(bk_len[esc] + RAW_LEN);
                        if (bits_sent > 32'(buf_limit) * 8)
                            ovf = 1'b1;
                    end else if (hit >= 0) begin
                        if (emit_bits(bk_code[hit], bk_len[hit]))
                            add_bits(bk_len[hit]);
                    end else if (emit_bits(bk_code[esc], bk_len[esc])) begin
                        add_bits(bk_len[esc]);
                        if (emit_bits(sym, RAW_LEN))
                            add_bits(RAW_LEN);
                    end
                    st = ovf ? hfe_pkg::STATUS_OVERFLOW : hfe_pkg::STATUS_OK;
                end
                rep = 24'(bits_sent);
            end
            hfe_pkg::FUNC_FLUSH: begin
                if (acc_bits != 0)
                    new_bytes.push_back(acc_byte);
                st        = ovf ? hfe_pkg::STATUS_OVERFLOW : hfe_pkg::STATUS_OK;
                rep       = 24'(bits_sent);
                acc_byte  = '0;
                acc_bits  = 0;
                bytes_out = '0;
                bits_sent = 0;
                ovf       = 1'b0;
            end
            default: begin
                st  = ovf ? hfe_pkg::STATUS_OVERFLOW : hfe_pkg::STATUS_OK;
                rep = 24'(bits_sent);
            end
        endcase
        nres = (new_bytes.size() > hfe_pkg::MAX_BYTES) ? hfe_pkg::MAX_BYTES
                                                       : new_bytes.size();
        w.total_bits  = rep;
        w.status      = st;
        w.used_escape = escaped;
        if (nres == 0) begin
            w.out_byte   = '0;
            w.byte_valid = 1'b0;
            w.last       = 1'b1;
            coded_words_q.push_back(w);
        end
        for (int k = 0; k < nres; k++) begin
            w.out_byte   = new_bytes[k];
            w.byte_valid = 1'b1;
            w.last       = (k == nres - 1);
            coded_words_q.push_back(w);
        end
    endfunction

    function automatic void compare_field(input string name, input logic [23:0] want,
                                          input logic [23:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // result side
    always @(posedge aclk) begin
        hfe_pkg::res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (coded_words_q.size() == 0) begin
                $error("output word with nothing expected: byte %0d", m_out_byte);
                errors++;
            end else begin
                want = coded_words_q.pop_front();
                compare_field("out_byte", want.out_byte, m_out_byte);
                compare_field("byte_valid", want.byte_valid, m_byte_valid);
                compare_field("last", want.last, m_last);
                compare_field("total_bits", want.total_bits, m_total_bits);
                compare_field("status", want.status, m_status);
                compare_field("used_escape", want.used_escape, m_used_escape);
            end
        end
    end

    always @(posedge aclk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("static_huffman_escape_encoder: mismatch");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] index, input logic [15:0] data);
        case (index)
            hfe_pkg::CFG_CHECK_ONLY:     chk_mode  = data[0];
            hfe_pkg::CFG_BUFFER_BYTES:   buf_limit = data;
            hfe_pkg::CFG_ESCAPE_SYM:     esc_sym   = data;
            hfe_pkg::CFG_ENTRIES_IN_USE: n_slots   = data[6:0];
            default: ;
        endcase
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_word(input logic [1:0] func, input logic [5:0] idx,
                             input logic [15:0] esym, input logic [15:0] ecode,
                             input logic [4:0] elen, input logic [15:0] sym);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_func         <= func;
        s_entry_index  <= idx;
        s_entry_symbol <= esym;
        s_entry_code   <= ecode;
        s_entry_len    <= elen;
        s_symbol       <= sym;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        encode_item(func, idx, esym, ecode, elen, sym);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        do
            @(posedge aclk);
        while (coded_words_q.size() != 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_pace(input int idle, input int stall);
        idle_pct  = idle;
        stall_pct = stall;
    endtask

    task automatic send_random_item();
        int          pick;
        int          n;
        logic [1:0]  func;
        logic [15:0] sym;
        logic [4:0]  elen;
        pick = $urandom_range(99);
        n    = (n_slots > SLOTS) ? SLOTS : int'(n_slots);
        sym  = 16'($urandom);
        elen = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(16, 1));
        if (pick < 8) begin
            func = hfe_pkg::FUNC_LOAD;
        end else if (pick < 15) begin
            func = hfe_pkg::FUNC_FLUSH;
        end else if (pick < 17) begin
            func = FUNC_UNUSED;
        end else begin
            func = hfe_pkg::FUNC_ENCODE;
            if (pick < 72 && n > 0)
                sym = bk_sym[$urandom_range(n - 1)];
            else if (pick < 85)
                sym = esc_sym;
        end
        send_word(func, 6'($urandom_range(63)), 16'($urandom), 16'($urandom), elen, sym);
    endtask

    task automatic randomise_config();
        int r;
        int n;
        write_reg(hfe_pkg::CFG_CHECK_ONLY, 16'($urandom_range(3) == 0));
        r = $urandom_range(9);
        write_reg(hfe_pkg::CFG_BUFFER_BYTES, (r < 5) ? 16'hFFFF :
                                    (r < 8) ? 16'($urandom_range(40)) : 16'($urandom));
        r = $urandom_range(9);
        n = (r < 3) ? SLOTS : (r == 3) ? 0 : $urandom_range(SLOTS, 1);
        write_reg(hfe_pkg::CFG_ENTRIES_IN_USE, 16'(n));
        r = $urandom_range(9);
        write_reg(hfe_pkg::CFG_ESCAPE_SYM, (r < 7 && n > 0) ? bk_sym[$urandom_range(n - 1)] :
                                     (r == 7) ? 16'h7FFF : (r == 8) ? 16'h8000 : 16'($urandom));
    endtask

    task automatic test_reset_defaults();
        write_reg(hfe_pkg::CFG_CHECK_ONLY, 16'd0);
        write_reg(hfe_pkg::CFG_BUFFER_BYTES, 16'hFFFF);
        write_reg(hfe_pkg::CFG_ESCAPE_SYM, 16'h8000);
        write_reg(hfe_pkg::CFG_ENTRIES_IN_USE, 16'd0);
        // empty book: no escape slot
        send_word(hfe_pkg::FUNC_ENCODE, 6'd0, 16'h0000, 16'h0000, 5'd0, 16'h1234);
        send_word(FUNC_UNUSED, 6'h3F, 16'hFFFF, 16'hFFFF, 5'h1F, 16'hFFFF);
        wait_idle();
    endtask

    task automatic test_codebook_basics();
        send_word(hfe_pkg::FUNC_LOAD, 6'd0, 16'h0000, 16'h0000, 5'd1, 16'h0000);
        send_word(hfe_pkg::FUNC_LOAD, 6'd1, 16'h7FFF, 16'hFFFF, 5'd16, 16'h0000);
        // zero length code
        send_word(hfe_pkg::FUNC_LOAD, 6'd2, 16'hFFFF, 16'hFFFF, 5'd0, 16'h0000);
        // code bits above the length
        send_word(hfe_pkg::FUNC_LOAD, 6'd3, 16'h0005, 16'hFFF3, 5'd3, 16'h0000);
        // shadowed duplicate
        send_word(hfe_pkg::FUNC_LOAD, 6'd4, 16'h0005, 16'h0001, 5'd1, 16'h0000);
        // over-long code saturates
        send_word(hfe_pkg::FUNC_LOAD, 6'd5, 16'h0007, 16'hABCD, 5'd31, 16'h0000);
        send_word(hfe_pkg::FUNC_LOAD, 6'd6, 16'h8000, 16'h0006, 5'd3, 16'h0000);
        wait_idle();
        write_reg(hfe_pkg::CFG_ENTRIES_IN_USE, 16'd7);
        send_word(hfe_pkg::FUNC_ENCODE, 6'd0, 16'h0000, 16'h0000, 5'd0, 16'h0000);
        send_word(hfe_pkg::FUNC_ENCODE, 6'd0, 16'h0000, 16'h0000, 5'd0, 16'h7FFF);
        send_word(hfe_pkg::FUNC_ENCODE, 6'd0, 16'h0000, 16'h0000, 5'd0, 16'hFFFF);
        send_word(hfe_pkg::FUNC_ENCODE, 6'd0, 16'h0000, 16'h0000, 5'd0, 16'h0005);
        send_word(hfe_pkg::FUNC_ENCODE, 6'd0, 16'h0000, 16'h0000, 5'd0, 16'h0007);
        send_word(hfe_pkg::FUNC_ENCODE, 6'd0, 16'h0000, 16'h0000, 5'd0, 16'h8000);
        send_word(hfe_pkg::FUNC_ENCODE, 6'd0, 16'h0000, 16'h0000, 5'd0, 16'h1234);
        send_word(hfe_pkg::FUNC_FLUSH, 6'd0, 16'h0000, 16'h0000, 5'd0, 16'h0000);
        wait_idle();
    endtask

    task automatic test_missing_escape();
        write_reg(hfe_pkg::CFG_ESCAPE_SYM, 16'h0101);
        send_word(hfe_pkg::FUNC_ENCODE, 6'd0, 16'h0000, 16'h0000, 5'd0, 16'h1234);
        wait_idle();
        write_reg(hfe_pkg::CFG_ESCAPE_SYM, 16'h8000);
    endtask

    task automatic test_check_only();
        write_reg(hfe_pkg::CFG_CHECK_ONLY, 16'd1);
        write_reg(hfe_pkg::CFG_BUFFER_BYTES, 16'd1);
        send_word(hfe_pkg::FUNC_ENCODE, 6'd0, 16'h0000, 16'h0000, 5'd0, 16'h0000);
        send_word(hfe_pkg::FUNC_ENCODE, 6'd0, 16'h0000, 16'h0000, 5'd0, 16'h1234);
        send_word(hfe_pkg::FUNC_FLUSH, 6'd0, 16'h0000, 16'h0000, 5'd0, 16'h0000);
        wait_idle();
        write_reg(hfe_pkg::CFG_CHECK_ONLY, 16'd0);
    endtask

    task automatic test_overflow();
        write_reg(hfe_pkg::CFG_BUFFER_BYTES, 16'd0);
        send_word(hfe_pkg::FUNC_ENCODE, 6'd0, 16'h0000, 16'h0000, 5'd0, 16'h7FFF);
        send_word(hfe_pkg::FUNC_LOAD, 6'd0, 16'h0000, 16'h0000, 5'd1, 16'h0000);
        send_word(hfe_pkg::FUNC_FLUSH, 6'd0, 16'h0000, 16'h0000, 5'd0, 16'h0000);
        wait_idle();
        // stops inside the raw bits
        write_reg(hfe_pkg::CFG_BUFFER_BYTES, 16'd2);
        send_word(hfe_pkg::FUNC_ENCODE, 6'd0, 16'h0000, 16'h0000, 5'd0, 16'h1234);
        send_word(hfe_pkg::FUNC_FLUSH, 6'd0, 16'h0000, 16'h0000, 5'd0, 16'h0000);
        wait_idle();
        write_reg(hfe_pkg::CFG_BUFFER_BYTES, 16'hFFFF);
    endtask

    task automatic test_full_codebook();
        for (int i = 7; i < SLOTS; i++)
            send_word(hfe_pkg::FUNC_LOAD, 6'(i), 16'($urandom), 16'($urandom),
                      5'($urandom_range(16, 1)), 16'($urandom));
        wait_idle();
        write_reg(hfe_pkg::CFG_ENTRIES_IN_USE, 16'(SLOTS));
        write_reg(hfe_pkg::CFG_ESCAPE_SYM, bk_sym[SLOTS - 1]);
    endtask

    task automatic test_hold_off();
        set_pace(0, 0);
        hold_request = HOLD_CYCLES;
        repeat (25) send_random_item();
        wait_idle();
    endtask

    task automatic test_random_traffic();
        int idle_tab [4]  = '{0, 71, 0, 25};
        int stall_tab [4] = '{0, 0, 71, 25};
        for (int p = 0; p < 8; p++) begin
            set_pace(idle_tab[p / 2], stall_tab[p / 2]);
            randomise_config();
            repeat (20) send_random_item();
            wait_idle();
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_codebook_basics();
        test_missing_escape();
        test_check_only();
        test_overflow();
        test_full_codebook();
        test_hold_off();
        test_random_traffic();
        repeat (16) @(posedge aclk);
        if (errors == 0 && coded_words_q.size() == 0)
            $display("static_huffman_escape_encoder: match");
        else
            $display("static_huffman_escape_encoder: mismatch");
        $finish;
    end

endmodule

/* files.f */
rtl/hfe_pkg.sv
rtl/hfe_ram.sv
rtl/hfe_front.sv
rtl/hfe_engine.sv
rtl/static_huffman_escape_encoder.sv
tb/static_huffman_escape_encoder_tb.sv
